// ===== rtl/core/rsv_pkg.sv =====
// Shared types, widths and command codes for the running sample variance unit.
package rsv_pkg;

   // Field and state widths.
   localparam int SAMPLE_BITS    = 16;
   localparam int COUNT_BITS     = 16;
   localparam int SUM_BITS       = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_RAW_BITS    = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
   localparam int DIV_BITS       = 64;
   localparam int SQ_BITS        = (SQ_RAW_BITS > DIV_BITS) ? DIV_BITS : SQ_RAW_BITS;
   localparam int HALF_BITS      = (SUM_BITS + 1) / 2;
   localparam int MUL_BITS       = (SAMPLE_BITS > HALF_BITS) ? SAMPLE_BITS : HALF_BITS;
   localparam int PROD_BITS      = 2 * MUL_BITS;
   localparam int VAR_BITS       = 32;
   localparam int OUT_COUNT_BITS = 16;
   localparam int DIV_STEPS      = 2;

   // Multiplier operand selection.
   localparam logic [1:0] MUL_SS = 2'd0;
   localparam logic [1:0] MUL_LL = 2'd1;
   localparam logic [1:0] MUL_LH = 2'd2;
   localparam logic [1:0] MUL_HH = 2'd3;

   // Square-of-sum accumulator operations.
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_MID  = 2'd2;
   localparam logic [1:0] ACC_HIGH = 2'd3;

   // Divider operand sources.
   localparam logic DIV_SRC_SQUARE = 1'b0;
   localparam logic DIV_SRC_NUMER  = 1'b1;

   typedef struct packed {
      logic                           func;
      logic signed [SAMPLE_BITS-1:0]  sample;
   } req_type;

   typedef struct packed {
      logic [VAR_BITS-1:0]       variance_value;
      logic [OUT_COUNT_BITS-1:0] sample_count;
      logic                      dropped;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       accum;
      logic [1:0] mul_sel;
      logic [1:0] acc_op;
      logic       div_start;
      logic       div_src;
      logic       out_load;
   } rsv_cmd_type;

   typedef struct packed {
      logic func;
      logic full;
      logic n_le1;
      logic div_busy;
      logic out_free;
   } rsv_status_type;

endpackage

// ===== rtl/core/running_sample_variance_unit.sv =====
// Top level of the running sample variance unit.
// Each transaction either clears the statistics or adds one signed 16-bit sample, and each
// one returns the truncated unbiased variance (sumsq - sum*sum/n)/(n-1), saturated to 32
// bits and zero while the count is below two, with the sample count and a dropped flag for
// a sample that arrives once the count is full. One transaction is worked at a time. An add
// with two or more samples held, dropped or not, goes through setup and squaring on one
// shared half-width multiplier, then two 64-bit divisions on one iterative divider that
// retires two quotient bits per cycle, then loads the result register once the output is
// free. A clear, and an add that leaves a single sample, skip the squaring and the
// divisions. The next transaction is accepted in the cycle after the result is loaded,
// even while that result still waits to be taken.
module running_sample_variance_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rsv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsv_pkg::rsp_type rsp_data
);

   rsv_pkg::rsv_cmd_type    cmd;
   rsv_pkg::rsv_status_type status;

   rsv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rsv_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/rsv_div.sv =====
// Iterative restoring divider, two quotient bits per cycle.
module rsv_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rsv_pkg::DIV_BITS-1:0]    numerator,
   input  logic [rsv_pkg::COUNT_BITS-1:0]  divisor,
   output logic                            busy,
   output logic [rsv_pkg::DIV_BITS-1:0]    quotient
);

   localparam int DW        = rsv_pkg::DIV_BITS;
   localparam int CB        = rsv_pkg::COUNT_BITS;
   localparam int ITER      = DW / rsv_pkg::DIV_STEPS;
   localparam int CNT_BITS  = $clog2(ITER + 1);

   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]       quo_ff, quo_in;
   logic [CB-1:0]       rem_ff, rem_in;
   logic [CB-1:0]       dvs_ff, dvs_in;
   logic [DW-1:0]       quo_step;
   logic [CB-1:0]       rem_step;
   logic [CB:0]         trial;

   // The quotient register starts with the numerator and shifts quotient
   // bits in at the bottom as numerator bits leave at the top.
   always_comb begin
      rem_step = rem_ff;
      quo_step = quo_ff;
      trial    = '0;
      for (int i = 0; i < rsv_pkg::DIV_STEPS; i++) begin
         trial    = {rem_step, quo_step[DW-1]};
         quo_step = {quo_step[DW-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_step    = CB'(trial - {1'b0, dvs_ff});
            quo_step[0] = 1'b1;
         end else begin
            rem_step = CB'(trial);
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = CNT_BITS'(ITER);
         quo_in = numerator;
         rem_in = '0;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
         quo_in = quo_step;
         rem_in = rem_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/rsv_dpath.sv =====
// Datapath: statistics registers, shared multiplier, divider and result register.
module rsv_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  rsv_pkg::rsv_cmd_type    cmd,
   output rsv_pkg::rsv_status_type status,
   input  rsv_pkg::req_type        req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsv_pkg::rsp_type        rsp_data
);

   localparam int SB   = rsv_pkg::SAMPLE_BITS;
   localparam int CB   = rsv_pkg::COUNT_BITS;
   localparam int SUMW = rsv_pkg::SUM_BITS;
   localparam int SQW  = rsv_pkg::SQ_BITS;
   localparam int HB   = rsv_pkg::HALF_BITS;
   localparam int MW   = rsv_pkg::MUL_BITS;
   localparam int PW   = rsv_pkg::PROD_BITS;
   localparam int DW   = rsv_pkg::DIV_BITS;
   localparam int VW   = rsv_pkg::VAR_BITS;

   logic                 func_ff, func_in;
   logic                 drop_ff, drop_in;
   logic [SB-1:0]        sample_ff, sample_in;
   logic [SUMW-1:0]      sum_ff, sum_in;
   logic [SQW-1:0]       sq_ff, sq_in;
   logic [CB-1:0]        count_ff, count_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [DW-1:0]        acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsv_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic [SB-1:0]        smag;
   logic [SUMW-1:0]      sext;
   logic [SUMW-1:0]      mag;
   logic [MW-1:0]        mag_lo, mag_hi, smag_w;
   logic [MW-1:0]        op_a, op_b;
   logic [DW-1:0]        prod_ext;
   logic [DW-1:0]        div_num;
   logic [CB-1:0]        div_dvs;
   logic                 div_busy;
   logic [DW-1:0]        quotient;
   logic [VW-1:0]        var_sat;
   logic                 full, n_le1, out_free;

   assign full     = &count_ff;
   assign n_le1    = (count_ff[CB-1:1] == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign smag   = sample_ff[SB-1] ? (~sample_ff + SB'(1)) : sample_ff;
   assign sext   = {{CB{sample_ff[SB-1]}}, sample_ff};
   assign mag    = sum_ff[SUMW-1] ? (~sum_ff + SUMW'(1)) : sum_ff;
   assign mag_lo = MW'(mag[HB-1:0]);
   assign mag_hi = MW'(mag >> HB);
   assign smag_w = MW'(smag);

   always_comb begin
      case (cmd.mul_sel)
         rsv_pkg::MUL_SS: begin
            op_a = smag_w;
            op_b = smag_w;
         end
         rsv_pkg::MUL_LL: begin
            op_a = mag_lo;
            op_b = mag_lo;
         end
         rsv_pkg::MUL_LH: begin
            op_a = mag_lo;
            op_b = mag_hi;
         end
         rsv_pkg::MUL_HH: begin
            op_a = mag_hi;
            op_b = mag_hi;
         end
         default: begin
            op_a = smag_w;
            op_b = smag_w;
         end
      endcase
      prod_in = PW'(op_a) * PW'(op_b);
   end

   // The square of the sum is built from three half-width products:
   // low*low, twice low*high and high*high, each at its own weight.
   assign prod_ext = DW'(prod_ff);

   always_comb begin
      case (cmd.acc_op)
         rsv_pkg::ACC_HOLD: acc_in = acc_ff;
         rsv_pkg::ACC_LOAD: acc_in = prod_ext;
         rsv_pkg::ACC_MID:  acc_in = acc_ff + (prod_ext << (HB + 1));
         rsv_pkg::ACC_HIGH: acc_in = acc_ff + (prod_ext << (2 * HB));
         default:           acc_in = acc_ff;
      endcase
   end

   always_comb begin
      func_in   = func_ff;
      sample_in = sample_ff;
      drop_in   = drop_ff;
      sum_in    = sum_ff;
      sq_in     = sq_ff;
      count_in  = count_ff;
      if (cmd.load) begin
         func_in   = req_data.func;
         sample_in = req_data.sample;
         drop_in   = !req_data.func && full;
      end
      if (cmd.clear) begin
         sum_in   = '0;
         sq_in    = '0;
         count_in = '0;
      end else if (cmd.accum) begin
         sum_in   = sum_ff + sext;
         sq_in    = sq_ff + SQW'(prod_ff);
         count_in = count_ff + CB'(1);
      end
   end

   always_comb begin
      if (cmd.div_src == rsv_pkg::DIV_SRC_NUMER) begin
         div_num = DW'(sq_ff) - quotient;
         div_dvs = count_ff - CB'(1);
      end else begin
         div_num = acc_ff;
         div_dvs = count_ff;
      end
   end

   rsv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .numerator (div_num),
      .divisor   (div_dvs),
      .busy      (div_busy),
      .quotient  (quotient)
   );

   assign var_sat = (quotient[DW-1:VW] != '0) ? '1 : quotient[VW-1:0];

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.variance_value = n_le1 ? '0 : var_sat;
         rsp_data_in.sample_count   = rsv_pkg::OUT_COUNT_BITS'(count_ff);
         rsp_data_in.dropped        = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         sq_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      sample_ff   <= sample_in;
      drop_ff     <= drop_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.func     = func_ff;
   assign status.full     = full;
   assign status.n_le1    = n_le1;
   assign status.div_busy = div_busy;
   assign status.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/rsv_ctrl.sv =====
// Controller state machine that sequences one transaction through the datapath.
module rsv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output rsv_pkg::rsv_cmd_type    cmd,
   input  rsv_pkg::rsv_status_type status
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_ACC    = 4'd2;
   localparam logic [3:0] S_CHECK  = 4'd3;
   localparam logic [3:0] S_M1     = 4'd4;
   localparam logic [3:0] S_M2     = 4'd5;
   localparam logic [3:0] S_M3     = 4'd6;
   localparam logic [3:0] S_D1S    = 4'd7;
   localparam logic [3:0] S_D1W    = 4'd8;
   localparam logic [3:0] S_D2S    = 4'd9;
   localparam logic [3:0] S_D2W    = 4'd10;
   localparam logic [3:0] S_FIN    = 4'd11;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = rsv_pkg::MUL_SS;
      cmd.acc_op  = rsv_pkg::ACC_HOLD;
      cmd.div_src = rsv_pkg::DIV_SRC_SQUARE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // A clear or a dropped sample leaves nothing to accumulate.
            if (status.func) begin
               cmd.clear = 1'b1;
               state_in  = S_CHECK;
            end else if (status.full) begin
               state_in = S_CHECK;
            end else begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.accum = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (status.n_le1) begin
               state_in = S_FIN;
            end else begin
               cmd.mul_sel = rsv_pkg::MUL_LL;
               state_in    = S_M1;
            end
         end
         S_M1: begin
            cmd.mul_sel = rsv_pkg::MUL_LH;
            cmd.acc_op  = rsv_pkg::ACC_LOAD;
            state_in    = S_M2;
         end
         S_M2: begin
            cmd.mul_sel = rsv_pkg::MUL_HH;
            cmd.acc_op  = rsv_pkg::ACC_MID;
            state_in    = S_M3;
         end
         S_M3: begin
            cmd.acc_op = rsv_pkg::ACC_HIGH;
            state_in   = S_D1S;
         end
         S_D1S: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = rsv_pkg::DIV_SRC_SQUARE;
            state_in      = S_D1W;
         end
         S_D1W: begin
            if (!status.div_busy) begin
               state_in = S_D2S;
            end
         end
         S_D2S: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = rsv_pkg::DIV_SRC_NUMER;
            state_in      = S_D2W;
         end
         S_D2W: begin
            if (!status.div_busy) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== rtl/core/rsv_checker.sv =====
// Port-level checker for the running sample variance unit and its bind.
module rsv_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input rsv_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rsv_pkg::rsp_type rsp_data
);

   // A waiting result must hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or vanished while stalled");

   // Only one transaction is in work, so the input stalls right after acceptance.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after a transaction was accepted");

   // A sample is dropped only when the count is already full.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |-> rsp_data.sample_count == 16'hFFFF)
      else $error("dropped flag set with count not full");

   // Fewer than two samples give zero variance.
   a_low_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.sample_count[15:1] == 15'd0) |->
         rsp_data.variance_value == 32'd0)
      else $error("nonzero variance with fewer than two samples");

endmodule

bind running_sample_variance_unit rsv_checker u_checker (.*);

// ===== tb/tb_running_sample_variance_unit.sv =====
// Self-checking testbench for the running sample variance unit.
`timescale 1ns / 1ps

module tb_running_sample_variance_unit;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;
   localparam logic [rsv_pkg::COUNT_BITS-1:0] COUNT_FULL = {rsv_pkg::COUNT_BITS{1'b1}};
   localparam logic [rsv_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
      {1'b1, {(rsv_pkg::SAMPLE_BITS-1){1'b0}}};
   localparam logic [rsv_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
      {1'b0, {(rsv_pkg::SAMPLE_BITS-1){1'b1}}};
   localparam int RANDOM_ITEMS = 1200;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT      = 100;

   logic             clock;
   logic             reset;
   logic             req_valid = 1'b0;
   logic             req_stall;
   rsv_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall;
   rsv_pkg::rsp_type rsp_data;

   logic stall_burst = 1'b0;
   logic long_hold   = 1'b0;
   assign rsp_stall = stall_burst | long_hold;

   rsv_pkg::req_type pending_items[$];
   rsv_pkg::rsp_type expected_stats[$];
   rsv_pkg::rsp_type want_stats;

   int idle_limit   = 0;
   int sent_count   = 0;
   int results_seen = 0;
   int fail_count   = 0;
   int gap_left     = 0;
   int stall_left   = 0;
   int hold_left    = 0;
   logic hold_done  = 1'b0;

   // Predicted statistics; the sum is kept as a 64-bit two's complement value.
   logic [63:0]                    acc_sum;
   logic [63:0]                    acc_sq;
   logic [rsv_pkg::COUNT_BITS-1:0] acc_n;

   running_sample_variance_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsv_pkg::rsp_type predict_variance(rsv_pkg::req_type item);
      logic [63:0]      sext, smag, mag, quot, numer, var64, n64;
      rsv_pkg::rsp_type r;
      r = '0;
      if (item.func == FUNC_CLEAR) begin
         acc_sum = '0;
         acc_sq  = '0;
         acc_n   = '0;
      end else if (acc_n == COUNT_FULL) begin
         r.dropped = 1'b1;
      end else begin
         sext    = {{(64-rsv_pkg::SAMPLE_BITS){item.sample[rsv_pkg::SAMPLE_BITS-1]}},
                    item.sample};
         smag    = sext[63] ? (64'd0 - sext) : sext;
         acc_sum = acc_sum + sext;
         acc_sq  = acc_sq + smag * smag;
         acc_n   = acc_n + 1'b1;
      end
      n64 = 64'(acc_n);
      if (n64 <= 64'd1) begin
         var64 = '0;
      end else begin
         mag   = acc_sum[63] ? (64'd0 - acc_sum) : acc_sum;
         quot  = (mag * mag) / n64;
         numer = acc_sq - quot;
         var64 = numer / (n64 - 64'd1);
      end
      r.variance_value = (var64 > 64'hFFFF_FFFF) ? '1 : var64[rsv_pkg::VAR_BITS-1:0];
      r.sample_count   = rsv_pkg::OUT_COUNT_BITS'(acc_n);
      return r;
   endfunction

   // Samples lean toward the extremes so that sums and squares get large.
   function automatic logic [rsv_pkg::SAMPLE_BITS-1:0] pick_sample();
      logic [rsv_pkg::SAMPLE_BITS-1:0] s;
      case ($urandom_range(0, 9))
         0: begin
            s = SAMPLE_MIN;
         end
         1: begin
            s = SAMPLE_MAX;
         end
         2: begin
            s = '0;
         end
         3: begin
            s = '1;
         end
         4: begin
            s = rsv_pkg::SAMPLE_BITS'(1);
         end
         default: begin
            s = rsv_pkg::SAMPLE_BITS'($urandom());
         end
      endcase
      return s;
   endfunction

   task automatic queue_item(logic func, logic [rsv_pkg::SAMPLE_BITS-1:0] sample);
      rsv_pkg::req_type item;
      item.func   = func;
      item.sample = sample;
      pending_items.push_back(item);
   endtask

   // Driver: the next transaction is offered only once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_stats.push_back(predict_variance(req_data));
            sent_count <= sent_count + 1;
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            if (sent_count < idle_limit && $urandom_range(0, 3) == 0) begin
               gap_left  <= $urandom_range(0, 7);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: each result transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         stall_burst <= 1'b0;
         stall_left  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stats.size() == 0) begin
               $error("unexpected result transaction: variance_value %0d %s %0d %s %0d",
                      rsp_data.variance_value, "sample_count", rsp_data.sample_count,
                      "dropped", rsp_data.dropped);
               fail_count++;
            end else begin
               want_stats = expected_stats.pop_front();
               if (rsp_data.variance_value !== want_stats.variance_value) begin
                  $error("variance_value: expected %0d, actual %0d",
                         want_stats.variance_value, rsp_data.variance_value);
                  fail_count++;
               end
               if (rsp_data.sample_count !== want_stats.sample_count) begin
                  $error("sample_count: expected %0d, actual %0d",
                         want_stats.sample_count, rsp_data.sample_count);
                  fail_count++;
               end
               if (rsp_data.dropped !== want_stats.dropped) begin
                  $error("dropped: expected %0d, actual %0d",
                         want_stats.dropped, rsp_data.dropped);
                  fail_count++;
               end
            end
            results_seen <= results_seen + 1;
         end
         if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            stall_burst <= 1'b1;
         end else if (results_seen < idle_limit && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 7);
            stall_burst <= 1'b1;
         end else begin
            stall_burst <= 1'b0;
         end
      end
   end

   // One long hold-off on the result side so that the unit backs up its input.
   always @(posedge clock) begin
      if (reset) begin
         long_hold <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (long_hold) begin
         if (hold_left == 0) begin
            long_hold <= 1'b0;
         end else begin
            hold_left <= hold_left - 1;
         end
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         long_hold <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   initial begin
      #250_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset   = 1'b1;
      acc_sum = '0;
      acc_sq  = '0;
      acc_n   = '0;

      // Directed: extremes, clears carrying a sample, and the one-sample case.
      queue_item(FUNC_CLEAR, '0);
      queue_item(FUNC_ADD, SAMPLE_MAX);
      queue_item(FUNC_ADD, SAMPLE_MIN);
      queue_item(FUNC_ADD, '0);
      queue_item(FUNC_ADD, '1);
      queue_item(FUNC_ADD, rsv_pkg::SAMPLE_BITS'(1));
      queue_item(FUNC_CLEAR, SAMPLE_MAX);
      queue_item(FUNC_ADD, SAMPLE_MIN);
      queue_item(FUNC_ADD, SAMPLE_MIN);
      queue_item(FUNC_ADD, SAMPLE_MAX);
      queue_item(FUNC_CLEAR, SAMPLE_MIN);
      queue_item(FUNC_ADD, rsv_pkg::SAMPLE_BITS'(1));
      queue_item(FUNC_CLEAR, '1);
      queue_item(FUNC_ADD, SAMPLE_MIN);
      queue_item(FUNC_ADD, SAMPLE_MAX);
      queue_item(FUNC_ADD, rsv_pkg::SAMPLE_BITS'(12345));
      queue_item(FUNC_ADD, rsv_pkg::SAMPLE_BITS'(-12345));
      queue_item(FUNC_ADD, SAMPLE_MAX);
      queue_item(FUNC_ADD, SAMPLE_MAX);
      queue_item(FUNC_CLEAR, '0);

      // Random runs of samples broken up by occasional clears.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         queue_item(($urandom_range(0, 39) == 0) ? FUNC_CLEAR : FUNC_ADD,
                    rsv_pkg::SAMPLE_BITS'($urandom()));
         pending_items[$].sample = ($urandom_range(0, 1) == 0) ? pick_sample()
                                                                 : pending_items[$].sample;
      end
      idle_limit = pending_items.size();

      // Fill the count to its maximum, then push samples that must be dropped.
      queue_item(FUNC_CLEAR, '0);
      for (int i = 0; i < int'(COUNT_FULL); i++) begin
         queue_item(FUNC_ADD, pick_sample());
      end
      queue_item(FUNC_ADD, SAMPLE_MAX);
      queue_item(FUNC_ADD, SAMPLE_MIN);
      queue_item(FUNC_ADD, pick_sample());
      queue_item(FUNC_CLEAR, '0);
      queue_item(FUNC_ADD, pick_sample());
      queue_item(FUNC_ADD, pick_sample());

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid) @(posedge clock);
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (fail_count == 0 && expected_stats.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
